// ===== hdl/assert_macros.svh =====
// assertion macros for the tokenizer rtl
// depends on a clk and an active-low rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked check, held off while in reset
`define HRT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that only applies while a result transaction is presented
`define HRT_ASSERT_VALID(label, vld, prop, msg) \
    `HRT_ASSERT(label, (vld) |-> (prop), msg)

`endif

// ===== hdl/hrt_pkg.sv =====
// shared types, phase/class/field codes and the byte classifier
// for the http request header tokenizer; no dependencies
`default_nettype none

package hrt_pkg;

    // parse phases
    localparam logic [3:0] PH_METHOD = 4'd0;
    localparam logic [3:0] PH_URL    = 4'd1;
    localparam logic [3:0] PH_PROTO  = 4'd2;
    localparam logic [3:0] PH_HEADER = 4'd3;
    localparam logic [3:0] PH_NAME   = 4'd4;
    localparam logic [3:0] PH_SEP    = 4'd5;
    localparam logic [3:0] PH_VALUE  = 4'd6;
    localparam logic [3:0] PH_DONE   = 4'd7;
    localparam logic [3:0] PH_ERR    = 4'd8;

    // byte classes
    localparam logic [2:0] CL_SPACE = 3'd0;
    localparam logic [2:0] CL_CR    = 3'd1;
    localparam logic [2:0] CL_LF    = 3'd2;
    localparam logic [2:0] CL_COLON = 3'd3;
    localparam logic [2:0] CL_OTHER = 3'd4;

    // field kinds
    localparam logic [2:0] FK_NONE   = 3'd0;
    localparam logic [2:0] FK_METHOD = 3'd1;
    localparam logic [2:0] FK_URL    = 3'd2;
    localparam logic [2:0] FK_PROTO  = 3'd3;
    localparam logic [2:0] FK_NAME   = 3'd4;
    localparam logic [2:0] FK_VALUE  = 3'd5;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] content_kind;
        logic [2:0] closed_kind;
        logic       request_done;
        logic       parse_error;
    } hrt_result_t;

    function automatic logic [2:0] classify(input logic [7:0] b);
        logic [2:0] cls;
        unique case (b)
            CH_SPACE: cls = CL_SPACE;
            CH_CR:    cls = CL_CR;
            CH_LF:    cls = CL_LF;
            CH_COLON: cls = CL_COLON;
            default:  cls = CL_OTHER;
        endcase
        return cls;
    endfunction

    // field carried by a phase
    function automatic logic [2:0] phase_field(input logic [3:0] ph);
        logic [2:0] fk;
        unique case (ph)
            PH_METHOD: fk = FK_METHOD;
            PH_URL:    fk = FK_URL;
            PH_PROTO:  fk = FK_PROTO;
            PH_NAME:   fk = FK_NAME;
            PH_VALUE:  fk = FK_VALUE;
            default:   fk = FK_NONE;
        endcase
        return fk;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/http_request_header_tokenizer.sv =====
// top level of the http request header tokenizer: input register, phase
// register, tagging logic and result register; depends on hrt_pkg,
// hrt_step, hrt_out_reg and assert_macros.svh
//
//   channel   signals                                   direction
//   byte      byte_valid, byte_stall, in_byte           into block
//   tag       tag_valid, tag_stall, out_byte,           out of block
//             content_kind, closed_kind, request_done,
//             parse_error
//
// one byte per cycle sustained while the tag port does not stall; each byte
// passes through the input register and then the result register to the tag port
// the phase register closes a loop through the combinational transition table
// reset clears both valid flags and puts the phase at method
// a stalled tag port holds its result; the input register then holds its
// byte and byte_stall rises until the result register frees
`default_nettype none

module http_request_header_tokenizer
    import hrt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_stall,
    input  wire logic [7:0] in_byte,
    output logic            tag_valid,
    input  wire logic       tag_stall,
    output logic [7:0]      out_byte,
    output logic [2:0]      content_kind,
    output logic [2:0]      closed_kind,
    output logic            request_done,
    output logic            parse_error
);

    `include "assert_macros.svh"

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_byte_reg;
    logic [3:0]  phase_reg;
    logic [3:0]  phase_next;
    logic [3:0]  step_phase;
    logic        res_ready;
    logic        move;
    logic        take;
    hrt_result_t step_result;

    // byte moves from input register to result register
    assign move       = in_valid_reg && res_ready;
    // input register full and unable to drain
    assign byte_stall = in_valid_reg && !res_ready;
    assign take       = byte_valid && !byte_stall;

    assign in_valid_next = take || (in_valid_reg && !move);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_byte_reg <= in_byte;
    end

    // phase advances only when the byte is committed to the result register
    assign phase_next = move ? step_phase : phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_METHOD;
        else
            phase_reg <= phase_next;
    end

    hrt_step u_step (
        .phase      (phase_reg),
        .data       (in_byte_reg),
        .result     (step_result),
        .phase_next (step_phase)
    );

    hrt_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (move),
        .result       (step_result),
        .ready        (res_ready),
        .tag_valid    (tag_valid),
        .tag_stall    (tag_stall),
        .out_byte     (out_byte),
        .content_kind (content_kind),
        .closed_kind  (closed_kind),
        .request_done (request_done),
        .parse_error  (parse_error)
    );

    // error phase is sticky
    `HRT_ASSERT(a_err_sticky, phase_reg == PH_ERR |=> phase_reg == PH_ERR, "error phase left")
    // phase never holds an unused code
    `HRT_ASSERT(a_phase_range, phase_reg <= PH_ERR, "phase code out of range")
    // an error result carries no tags
    `HRT_ASSERT_VALID(a_err_quiet, tag_valid && parse_error, content_kind == FK_NONE && closed_kind == FK_NONE && !request_done, "error result tagged")
    // a completing byte is no content and closes nothing
    `HRT_ASSERT_VALID(a_done_quiet, tag_valid && request_done, content_kind == FK_NONE && closed_kind == FK_NONE && !parse_error, "done result tagged")

endmodule

`default_nettype wire

// ===== hdl/hrt_step.sv =====
// combinational phase transition and byte tagging for one byte
// depends on hrt_pkg
`default_nettype none

module hrt_step
    import hrt_pkg::*;
(
    input  wire logic [3:0]  phase,
    input  wire logic [7:0]  data,
    output hrt_result_t      result,
    output logic [3:0]       phase_next
);

    logic [2:0] cls;
    logic [3:0] nx;

    assign cls = classify(data);

    // transition table, unused phase codes behave as error
    always_comb
    begin
        nx = PH_ERR;
        unique case (phase)
            PH_METHOD:
            begin
                if (cls == CL_SPACE)      nx = PH_URL;
                else if (cls == CL_OTHER) nx = PH_METHOD;
            end
            PH_URL:
            begin
                if (cls == CL_SPACE)                           nx = PH_PROTO;
                else if (cls == CL_COLON || cls == CL_OTHER)   nx = PH_URL;
            end
            PH_PROTO:
            begin
                if (cls == CL_CR)         nx = PH_HEADER;
                else if (cls == CL_LF)    nx = PH_NAME;
                else if (cls == CL_OTHER) nx = PH_PROTO;
            end
            PH_HEADER:
            begin
                if (cls == CL_LF) nx = PH_NAME;
            end
            PH_NAME:
            begin
                if (cls == CL_SPACE || cls == CL_COLON) nx = PH_SEP;
                else if (cls == CL_CR)                  nx = PH_DONE;
                else if (cls == CL_OTHER)               nx = PH_NAME;
            end
            PH_SEP:
            begin
                if (cls == CL_SPACE || cls == CL_COLON) nx = PH_SEP;
                else if (cls == CL_OTHER)               nx = PH_VALUE;
            end
            PH_VALUE:
            begin
                if (cls == CL_CR)      nx = PH_HEADER;
                else if (cls == CL_LF) nx = PH_NAME;
                else                   nx = PH_VALUE;
            end
            PH_DONE: nx = PH_METHOD;
            default: nx = PH_ERR;
        endcase
    end

    always_comb
    begin
        result.data         = data;
        result.content_kind = FK_NONE;
        result.closed_kind  = FK_NONE;
        result.request_done = 1'b0;
        result.parse_error  = (nx == PH_ERR);
        if (phase == PH_DONE)
        begin
            result.request_done = 1'b1;
        end
        else if (nx == phase)
        begin
            result.content_kind = phase_field(phase);
        end
        else if (nx != PH_ERR)
        begin
            result.closed_kind = phase_field(phase);
            // first value byte is kept as value content
            if (phase == PH_SEP)
                result.content_kind = FK_VALUE;
        end
    end

    assign phase_next = nx;

endmodule

`default_nettype wire

// ===== hdl/hrt_out_reg.sv =====
// result register with valid/stall handshake toward the consumer
// depends on hrt_pkg
`default_nettype none

module hrt_out_reg
    import hrt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire hrt_result_t result,
    output logic             ready,
    output logic             tag_valid,
    input  wire logic        tag_stall,
    output logic [7:0]       out_byte,
    output logic [2:0]       content_kind,
    output logic [2:0]       closed_kind,
    output logic             request_done,
    output logic             parse_error
);

    logic        valid_reg;
    logic        valid_next;
    hrt_result_t data_reg;

    // free when empty or the held transaction leaves this cycle
    assign ready      = !valid_reg || !tag_stall;
    assign valid_next = load || (valid_reg && tag_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign tag_valid    = valid_reg;
    assign out_byte     = data_reg.data;
    assign content_kind = data_reg.content_kind;
    assign closed_kind  = data_reg.closed_kind;
    assign request_done = data_reg.request_done;
    assign parse_error  = data_reg.parse_error;

endmodule

`default_nettype wire
